[hw/rtl/ipcf_pkg.sv]
`default_nettype none

package ipcf_pkg;

  // Fixed field widths of the stream payload.
  localparam int COUNT_W     = 4;
  localparam int UNIT_PORT_W = 16;
  localparam int WIN         = 8;
  localparam int IN_DATA_W   = 168;
  localparam int OUT_DATA_W  = 8;

  localparam int UNIT_BITS_DEF = 16;

  localparam int NUM_KEYS    = 17;
  localparam int KEY_MAX_LEN = 6;

  typedef enum logic [2:0] {
    REASON_NONE      = 3'd0,
    REASON_BAD_PREV  = 3'd1,
    REASON_HEX_BRACE = 3'd2,
    REASON_ZERO_DOT  = 3'd3,
    REASON_KEYWORD   = 3'd4
  } reason_t;

  // Keyword table: lowest window position a match may start at, its length,
  // and its text (unused tail bytes are zero and never compared).
  localparam int KEY_START [NUM_KEYS] = '{
    5, 5, 5, 4, 4, 4, 4, 4, 4, 0, 0, 0, 0, 0, 4, 0, 0
  };

  localparam int KEY_LEN [NUM_KEYS] = '{
    2, 2, 3, 2, 2, 2, 3, 3, 3, 5, 4, 4, 6, 6, 3, 6, 5
  };

  localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_MAX_LEN] = '{
    '{"v", ".", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "v", ":", 8'h00, 8'h00, 8'h00},
    '{">", "=", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"<", "=", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"<", "<", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "e", "r", 8'h00, 8'h00, 8'h00},
    '{"V", "e", "r", 8'h00, 8'h00, 8'h00},
    '{"V", "E", "R", 8'h00, 8'h00, 8'h00},
    '{"r", "s", "i", "o", "n", 8'h00},
    '{"i", "o", "n", "=", 8'h00, 8'h00},
    '{"P", "S", "W", "/", 8'h00, 8'h00},
    '{"f", "l", "a", "s", "h", "="},
    '{"s", "t", "o", "n", "e", "="},
    '{"N", "S", "S", 8'h00, 8'h00, 8'h00},
    '{"/", "2", "0", "0", "1", ","},
    '{"T", "I", "_", "S", "Z", 8'h00}
  };

endpackage

`default_nettype wire

[hw/rtl/ipcf_kwmatch.sv]
`default_nettype none

// Flags a context window that holds any of the version-like keywords
// wholly inside that keyword's allowed span of positions.
module ipcf_kwmatch #(
  parameter int UNIT_BITS = ipcf_pkg::UNIT_BITS_DEF
) (
  input  wire logic [UNIT_BITS-1:0] ctx [ipcf_pkg::WIN],
  output      logic                 key_hit
);

  logic [ipcf_pkg::NUM_KEYS-1:0] hit_vec;

  for (genvar k = 0; k < ipcf_pkg::NUM_KEYS; k++) begin : g_key
    logic [ipcf_pkg::WIN-1:0] pos_hit;

    for (genvar s = 0; s < ipcf_pkg::WIN; s++) begin : g_pos
      if ((s >= ipcf_pkg::KEY_START[k]) &&
          (s + ipcf_pkg::KEY_LEN[k] <= ipcf_pkg::WIN)) begin : g_on
        logic [ipcf_pkg::KEY_MAX_LEN-1:0] eq;
        for (genvar j = 0; j < ipcf_pkg::KEY_MAX_LEN; j++) begin : g_chr
          if (j < ipcf_pkg::KEY_LEN[k]) begin : g_cmp
            assign eq[j] = (ctx[s+j] == UNIT_BITS'(ipcf_pkg::KEY_TEXT[k][j]));
          end else begin : g_pad
            assign eq[j] = 1'b1;
          end
        end
        assign pos_hit[s] = &eq;
      end else begin : g_off
        assign pos_hit[s] = 1'b0;
      end
    end

    assign hit_vec[k] = |pos_hit;
  end

  assign key_hit = |hit_vec;

endmodule

`default_nettype wire

[hw/rtl/ip_address_context_filter_core.sv]
// Three register stages: input capture with padding, classification, output.
// out_tvalid rises once an item reaches the output register, after the capture and classification registers.
// Throughput is one item per cycle while out_tready stays high; each stage advances whenever the next one is free.
// rst_n is synchronous and active low; it clears the stage valid bits only.
// There is no internal state between items and no clearing pass after reset.
`default_nettype none

module ip_address_context_filter_core #(
  parameter int UNIT_BITS = ipcf_pkg::UNIT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // context_count, prev_unit_0 .. prev_unit_7, hit_first_unit,
  // hit_second_unit, four zero bits on top
  input  wire logic [ipcf_pkg::IN_DATA_W-1:0]  in_tdata,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // accepted, reject_reason, four zero bits on top
  output      logic [ipcf_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int WIN = ipcf_pkg::WIN;
  localparam int CW  = ipcf_pkg::COUNT_W;
  localparam int UPW = ipcf_pkg::UNIT_PORT_W;

  typedef struct packed {
    logic bad_prev;
    logic hex_brace;
    logic zero_dot;
    logic keyword;
  } flags_t;

  function automatic logic is_digit(input logic [UNIT_BITS-1:0] c);
    return (c >= UNIT_BITS'("0")) && (c <= UNIT_BITS'("9"));
  endfunction

  function automatic logic is_alnum(input logic [UNIT_BITS-1:0] c);
    return is_digit(c) ||
           ((c >= UNIT_BITS'("a")) && (c <= UNIT_BITS'("z"))) ||
           ((c >= UNIT_BITS'("A")) && (c <= UNIT_BITS'("Z")));
  endfunction

  function automatic logic is_hex(input logic [UNIT_BITS-1:0] c);
    return is_digit(c) ||
           ((c >= UNIT_BITS'("a")) && (c <= UNIT_BITS'("f"))) ||
           ((c >= UNIT_BITS'("A")) && (c <= UNIT_BITS'("F")));
  endfunction

  // Stage 1: padded, masked window.
  logic                 s1_valid_r;
  logic [UNIT_BITS-1:0] s1_ctx_r [WIN];
  logic [UNIT_BITS-1:0] s1_h0_r;
  logic [UNIT_BITS-1:0] s1_h1_r;
  logic [UNIT_BITS-1:0] s1_ctx_nxt [WIN];

  // Stage 2: rule flags.
  logic   s2_valid_r;
  flags_t s2_flags_r;
  flags_t s2_flags_nxt;

  // Stage 3: output register.
  logic                s3_valid_r;
  ipcf_pkg::reason_t   s3_reason_r;
  ipcf_pkg::reason_t   s3_reason_nxt;

  logic s2_ready;
  logic s3_ready;

  logic [CW-1:0] count_raw;
  logic [CW-1:0] count_cl;
  logic          key_hit;

  assign s3_ready  = !s3_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  assign count_raw = in_tdata[CW-1:0];
  assign count_cl  = (count_raw > CW'(WIN)) ? CW'(WIN) : count_raw;

  // Position i holds a real unit when it is among the last count_cl places.
  for (genvar i = 0; i < WIN; i++) begin : g_pad
    assign s1_ctx_nxt[i] =
      ((5'(i) + 5'(count_cl)) >= 5'(WIN)) ? in_tdata[CW + UPW*i +: UNIT_BITS]
                                           : UNIT_BITS'(" ");
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ctx_r <= s1_ctx_nxt;
      s1_h0_r  <= in_tdata[CW + UPW*WIN +: UNIT_BITS];
      s1_h1_r  <= in_tdata[CW + UPW*(WIN+1) +: UNIT_BITS];
    end
  end

  ipcf_kwmatch #(
    .UNIT_BITS (UNIT_BITS)
  ) u_kwmatch (
    .ctx     (s1_ctx_r),
    .key_hit (key_hit)
  );

  always_comb begin
    s2_flags_nxt.bad_prev  = is_alnum(s1_ctx_r[7]) ||
                             (s1_ctx_r[7] == UNIT_BITS'(".")) ||
                             (s1_ctx_r[7] == UNIT_BITS'("-")) ||
                             (s1_ctx_r[7] == UNIT_BITS'("+"));
    s2_flags_nxt.hex_brace = is_hex(s1_ctx_r[4]) && is_hex(s1_ctx_r[5]) &&
                             is_hex(s1_ctx_r[6]) &&
                             (s1_ctx_r[7] == UNIT_BITS'("}"));
    s2_flags_nxt.zero_dot  = (s1_h0_r == UNIT_BITS'("0")) &&
                             (s1_h1_r == UNIT_BITS'("."));
    s2_flags_nxt.keyword   = key_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_flags_r <= s2_flags_nxt;
    end
  end

  // The lowest reason code among the rules that fire wins.
  always_comb begin
    priority if (s2_flags_r.bad_prev) begin
      s3_reason_nxt = ipcf_pkg::REASON_BAD_PREV;
    end else if (s2_flags_r.hex_brace) begin
      s3_reason_nxt = ipcf_pkg::REASON_HEX_BRACE;
    end else if (s2_flags_r.zero_dot) begin
      s3_reason_nxt = ipcf_pkg::REASON_ZERO_DOT;
    end else if (s2_flags_r.keyword) begin
      s3_reason_nxt = ipcf_pkg::REASON_KEYWORD;
    end else begin
      s3_reason_nxt = ipcf_pkg::REASON_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_reason_r <= s3_reason_nxt;
    end
  end

  assign out_tvalid = s3_valid_r;
  assign out_tdata  = {4'b0000, s3_reason_r, (s3_reason_r == ipcf_pkg::REASON_NONE)};

endmodule

`default_nettype wire

[hw/rtl/ipcf_checker.sv]
`default_nettype none

module ipcf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [ipcf_pkg::OUT_DATA_W-1:0] out_tdata
);

  // Synchronous reset empties the output stage.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // The accept flag and the reason code must agree.
  a_accept_vs_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == ipcf_pkg::REASON_NONE)))
    else $error("accepted flag disagrees with reason");

  a_reason_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[3:1] == ipcf_pkg::REASON_NONE) ||
                    (out_tdata[3:1] == ipcf_pkg::REASON_BAD_PREV) ||
                    (out_tdata[3:1] == ipcf_pkg::REASON_HEX_BRACE) ||
                    (out_tdata[3:1] == ipcf_pkg::REASON_ZERO_DOT) ||
                    (out_tdata[3:1] == ipcf_pkg::REASON_KEYWORD)) &&
                   (out_tdata[7:4] == 4'b0000))
    else $error("illegal result code");

  // With out_tready held high while it passes the pipeline registers, an accepted item shows up on out_tvalid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind ip_address_context_filter_core ipcf_checker u_ipcf_checker (.*);

`default_nettype wire
